FILE: sv/websocket_frame_deframer_top_macros.svh
// Assertion macros shared by the deframer RTL files.
// Depends on nothing; expects clk and rst_n in the using module.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define WSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
// Next-cycle implication
`define WSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define WSD_ASSERT_IMP(lbl, ante, cons)
`define WSD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/wsd_pkg.sv
// Types and codes for the WebSocket frame deframer.
// No dependencies; used by wsd_parser and the top level.
`default_nettype none
package wsd_pkg;

  // Header parse phases
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_CLOSE = 2'd2,
    ST_UNSUP = 2'd3
  } status_t;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    status_t    frame_status;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/wsd_parser.sv
// Frame header parser and payload unmasking for one byte per transfer.
// Depends on wsd_pkg and the assertion macro header.
`default_nettype none
`include "websocket_frame_deframer_top_macros.svh"
module wsd_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,       // input transfer this cycle
  input  wire logic [7:0]      data_byte,
  input  wire logic            last,
  output wsd_pkg::result_t     result      // result for the byte at the input
);

  wsd_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [63:0]      remain_r, remain_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic             masked_r, masked_nxt;
  wsd_pkg::status_t pend_r, pend_nxt;

  logic [7:0]  key_byte;
  logic [3:0]  cnt_dec;
  logic [63:0] remain_dec;

  assign cnt_dec    = cnt_r - 4'd1;
  assign remain_dec = remain_r - 64'd1;

  // Key byte for the current payload index, first key byte at position 0
  always_comb begin
    unique case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next state and result
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    remain_nxt = remain_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    masked_nxt = masked_r;
    pend_nxt   = pend_r;
    result     = '0;

    unique case (phase_r)
      wsd_pkg::PH_HDR0: begin
        if (data_byte[3:0] == wsd_pkg::OP_CLOSE) begin
          pend_nxt = wsd_pkg::ST_CLOSE;
        end else if (data_byte[3:0] != wsd_pkg::OP_CONT &&
                     data_byte[3:0] != wsd_pkg::OP_TEXT) begin
          pend_nxt = wsd_pkg::ST_UNSUP;
        end else begin
          pend_nxt = wsd_pkg::ST_OK;
        end
        phase_nxt = wsd_pkg::PH_HDR1;
      end
      wsd_pkg::PH_HDR1: begin
        if (pend_r != wsd_pkg::ST_OK) begin
          phase_nxt = wsd_pkg::PH_DONE;
        end else begin
          masked_nxt = data_byte[7];
          remain_nxt = '0;
          if (data_byte[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_nxt = wsd_pkg::PH_EXTLEN;
            cnt_nxt   = wsd_pkg::EXT16_BYTES;
          end else if (data_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            phase_nxt = wsd_pkg::PH_EXTLEN;
            cnt_nxt   = wsd_pkg::EXT64_BYTES;
          end else begin
            remain_nxt = {57'd0, data_byte[6:0]};
            if (data_byte[7]) begin
              phase_nxt = wsd_pkg::PH_MASK;
              cnt_nxt   = wsd_pkg::KEY_BYTES;
            end else if (data_byte[6:0] == 7'd0) begin
              phase_nxt = wsd_pkg::PH_DONE;
            end else begin
              phase_nxt = wsd_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        remain_nxt = {remain_r[55:0], data_byte};
        cnt_nxt    = cnt_dec;
        if (cnt_dec == 4'd0) begin
          if (masked_r) begin
            phase_nxt = wsd_pkg::PH_MASK;
            cnt_nxt   = wsd_pkg::KEY_BYTES;
          end else if (remain_nxt == 64'd0) begin
            phase_nxt = wsd_pkg::PH_DONE;
          end else begin
            phase_nxt = wsd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsd_pkg::PH_MASK: begin
        key_nxt = {key_r[23:0], data_byte};
        cnt_nxt = cnt_dec;
        if (cnt_dec == 4'd0) begin
          phase_nxt = (remain_r == 64'd0) ? wsd_pkg::PH_DONE : wsd_pkg::PH_PAYLOAD;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        result.payload_byte  = data_byte ^ (masked_r ? key_byte : 8'd0);
        result.payload_valid = 1'b1;
        pos_nxt    = pos_r + 2'd1;
        remain_nxt = remain_dec;
        if (remain_dec == 64'd0) begin
          phase_nxt = wsd_pkg::PH_DONE;
        end
      end
      default: begin
        // finished: rest of the buffer is ignored
      end
    endcase

    // Last byte of the buffer: report and return to the header
    if (last) begin
      result.frame_done   = 1'b1;
      result.frame_status = (phase_nxt == wsd_pkg::PH_DONE) ? pend_nxt : wsd_pkg::ST_TRUNC;
      phase_nxt  = wsd_pkg::PH_HDR0;
      cnt_nxt    = '0;
      remain_nxt = '0;
      key_nxt    = '0;
      pos_nxt    = '0;
      masked_nxt = 1'b0;
      pend_nxt   = wsd_pkg::ST_OK;
    end
  end

  // Parse state registers, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      cnt_r    <= '0;
      remain_r <= '0;
      key_r    <= '0;
      pos_r    <= '0;
      masked_r <= 1'b0;
      pend_r   <= wsd_pkg::ST_OK;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      remain_r <= remain_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      masked_r <= masked_nxt;
      pend_r   <= pend_nxt;
    end
  end

  `WSD_ASSERT_NXT(a_last_back_to_hdr, step && last, phase_r == wsd_pkg::PH_HDR0)
  `WSD_ASSERT_IMP(a_payload_nonzero, phase_r == wsd_pkg::PH_PAYLOAD, remain_r != 64'd0)
  `WSD_ASSERT_IMP(a_key_count_range, phase_r == wsd_pkg::PH_MASK,
                  cnt_r != 4'd0 && cnt_r <= wsd_pkg::KEY_BYTES)

endmodule
`default_nettype wire

FILE: sv/websocket_frame_deframer_top.sv
// A result is on the output in the cycle after its input byte transfer.
// Throughput: one byte per cycle while no held result waits on out_tready, bounded
// by the parser's 64-bit length down-counter and zero compare, which sit between state and result register.
// The input stays ready while a held result is being taken in the same cycle.
// Reset (rst_n low, synchronous): parser to the first header byte, output empty.
// Top level: stream handshake and result register around wsd_parser.
// Depends on wsd_pkg, wsd_parser and the assertion macro header.
`default_nettype none
`include "websocket_frame_deframer_top_macros.svh"
module websocket_frame_deframer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // end_of_buffer
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] payload_byte
  output logic [2:0]      out_tuser,  // [0] payload_valid, [2:1] frame_status
  output logic            out_tlast   // frame_done
);

  logic             out_valid_r, out_valid_nxt;
  wsd_pkg::result_t res_r;
  wsd_pkg::result_t res_comb;
  logic             in_xfer;

  // Accept while the result register is empty or being emptied
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_xfer),
    .data_byte (in_tdata),
    .last      (in_tlast),
    .result    (res_comb)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_comb;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.payload_byte;
  assign out_tuser  = {res_r.frame_status, res_r.payload_valid};
  assign out_tlast  = res_r.frame_done;

  `WSD_ASSERT_NXT(a_xfer_gives_result, in_xfer, out_tvalid)
  `WSD_ASSERT_IMP(a_idle_byte_zero, out_tvalid && !out_tuser[0], out_tdata == 8'd0)
  `WSD_ASSERT_IMP(a_status_only_on_last, out_tvalid && !out_tlast, out_tuser[2:1] == wsd_pkg::ST_OK)

endmodule
`default_nettype wire
